/* rtl/srr_pkg.sv */
// Package for the selective repeat receiver: field widths, word layouts,
// result kinds, controller states and the command and status structs.
// Depends on nothing; the controller, datapath, top level and testbench import it.
package srr_pkg;

   localparam int SEQ_W          = 4;
   localparam int ACK_W          = 5;
   localparam int CHK_W          = 32;
   localparam int LOW_W          = 64;
   localparam int MID_W          = 64;
   localparam int HIGH_W         = 32;
   localparam int PAY_W          = LOW_W + MID_W + HIGH_W;
   localparam int PAY_BYTES      = PAY_W / 8;
   localparam int GRP_BYTES      = 4;
   localparam int GRP_N          = PAY_BYTES / GRP_BYTES;
   localparam int GRP_W          = 10;
   localparam int SUM_W          = 14;
   localparam int ACK_CHECK_W    = 10;
   localparam int ACK_CHECK_BASE = 959;

   localparam int REQ_FIELDS_W   = SEQ_W + ACK_W + CHK_W + PAY_W;
   localparam int REQ_DATA_W     = ((REQ_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_FIELDS_W   = SEQ_W + ACK_CHECK_W + PAY_W;
   localparam int RSP_DATA_W     = ((RSP_FIELDS_W + 7) / 8) * 8;

   localparam int SEQ_SPACE_DEF  = 12;
   localparam int WINDOW_DEF     = 6;

   localparam logic KIND_ACK     = 1'b0;
   localparam logic KIND_DELIVER = 1'b1;

   typedef enum logic [1:0] {
      IDLE_S,
      CHECK_S,
      ACK_S,
      DELIVER_S
   } state_type;

   typedef struct packed {
      logic load_pkt;
      logic commit;
      logic emit_ack;
      logic emit_dlv;
   } cmd_type;

   typedef struct packed {
      logic pkt_ok;
      logic out_free;
      logic head_empty;
      logic dlv_last;
   } status_type;

endpackage

/* rtl/srr_ram.sv */
// Generic single write port, single read port RAM with registered read data.
// Used for the slot payload store; depends on nothing.
module srr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  logic [WIDTH-1:0]           wr_data,
   input  logic [$clog2(DEPTH)-1:0]   rd_addr,
   output logic [WIDTH-1:0]           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/srr_ctrl.sv */
// Controller of the selective repeat receiver: sequences load, check,
// acknowledgement and in-order delivery. Depends on srr_pkg.
module srr_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  srr_pkg::status_type sts,
   output srr_pkg::cmd_type    cmd
);
   import srr_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE_S;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         IDLE_S: begin
            if (req_tvalid) begin
               state_in = CHECK_S;
            end
         end
         CHECK_S: begin
            state_in = sts.pkt_ok ? ACK_S : IDLE_S;
         end
         ACK_S: begin
            if (sts.out_free) begin
               state_in = sts.head_empty ? IDLE_S : DELIVER_S;
            end
         end
         DELIVER_S: begin
            if (sts.out_free && sts.dlv_last) begin
               state_in = IDLE_S;
            end
         end
         default: begin
            state_in = IDLE_S;
         end
      endcase
   end

   always_comb begin
      req_tready   = 1'b0;
      cmd          = '0;
      case (state_ff)
         IDLE_S: begin
            req_tready   = !reset;
            cmd.load_pkt = req_tvalid && !reset;
         end
         CHECK_S: begin
            cmd.commit = sts.pkt_ok;
         end
         ACK_S: begin
            cmd.emit_ack = sts.out_free;
         end
         DELIVER_S: begin
            cmd.emit_dlv = sts.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

/* rtl/srr_datapath.sv */
// Datapath of the selective repeat receiver: packet register, checksum and
// window test, slot store with fill bits, and the result register.
// Depends on srr_pkg and srr_ram.
module srr_datapath #(
   parameter int SEQ_SPACE = srr_pkg::SEQ_SPACE_DEF,
   parameter int WINDOW    = srr_pkg::WINDOW_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [srr_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  srr_pkg::cmd_type                cmd,
   output srr_pkg::status_type             sts,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [srr_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic                            rsp_tuser,
   output logic                            rsp_tlast
);
   import srr_pkg::*;

   localparam int IDX_W = $clog2(SEQ_SPACE);
   localparam int CNT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int DIF_W = SEQ_W + 1;

   logic [SEQ_W-1:0]        seq_ff;
   logic [ACK_W-1:0]        ack_ff;
   logic [CHK_W-1:0]        chk_ff;
   logic [PAY_W-1:0]        pay_ff;
   logic [GRP_W-1:0]        grp_ff [GRP_N];
   logic [GRP_W-1:0]        grp_in [GRP_N];
   logic [PAY_W-1:0]        req_pay;

   logic [IDX_W-1:0]        exp_ff;
   logic [IDX_W-1:0]        exp_in;
   logic [IDX_W-1:0]        exp_next;
   logic [SEQ_SPACE-1:0]    filled_ff;
   logic [SEQ_SPACE-1:0]    filled_in;
   logic [CNT_W-1:0]        cnt_ff;
   logic [CNT_W-1:0]        cnt_in;

   logic [SUM_W-1:0]        sum;
   logic                    sum_ok;
   logic                    range_ok;
   logic [DIF_W-1:0]        dif;
   logic                    win_ok;
   logic [IDX_W-1:0]        seq_idx;
   logic                    wr_en;
   logic [IDX_W-1:0]        rd_addr;
   logic [PAY_W-1:0]        rd_data;

   logic                    rsp_valid_ff;
   logic                    rsp_valid_in;
   logic                    rsp_kind_ff;
   logic                    rsp_last_ff;
   logic [SEQ_W-1:0]        rsp_num_ff;
   logic [ACK_CHECK_W-1:0]  rsp_chk_ff;
   logic [PAY_W-1:0]        rsp_pay_ff;

   assign req_pay = req_tdata[SEQ_W+ACK_W+CHK_W +: PAY_W];

   always_comb begin
      for (int g = 0; g < GRP_N; g++) begin
         grp_in[g] = '0;
         for (int b = 0; b < GRP_BYTES; b++) begin
            grp_in[g] = grp_in[g] + GRP_W'(req_pay[(g*GRP_BYTES+b)*8 +: 8]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_pkt) begin
         seq_ff <= req_tdata[0 +: SEQ_W];
         ack_ff <= req_tdata[SEQ_W +: ACK_W];
         chk_ff <= req_tdata[SEQ_W+ACK_W +: CHK_W];
         pay_ff <= req_pay;
         for (int g = 0; g < GRP_N; g++) begin
            grp_ff[g] <= grp_in[g];
         end
      end
   end

   always_comb begin
      sum = SUM_W'(seq_ff) + SUM_W'(signed'(ack_ff));
      for (int g = 0; g < GRP_N; g++) begin
         sum = sum + SUM_W'(grp_ff[g]);
      end
   end

   assign sum_ok   = (CHK_W'(signed'(sum)) == chk_ff);
   assign range_ok = (DIF_W'(seq_ff) < DIF_W'(SEQ_SPACE));
   assign seq_idx  = seq_ff[IDX_W-1:0];

   always_comb begin
      dif = DIF_W'(seq_ff) - DIF_W'(exp_ff);
      if (dif[DIF_W-1]) begin
         dif = dif + DIF_W'(SEQ_SPACE);
      end
   end

   assign win_ok     = (dif < DIF_W'(WINDOW));
   assign sts.pkt_ok = sum_ok && range_ok && win_ok;

   assign exp_next = (exp_ff == IDX_W'(SEQ_SPACE - 1)) ? '0 : exp_ff + 1'b1;
   assign wr_en    = cmd.commit && !filled_ff[seq_idx];
   assign rd_addr  = cmd.emit_dlv ? exp_next : exp_ff;

   srr_ram #(
      .WIDTH (PAY_W),
      .DEPTH (SEQ_SPACE)
   ) u_slots (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (seq_idx),
      .wr_data (pay_ff),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      filled_in = filled_ff;
      exp_in    = exp_ff;
      cnt_in    = cnt_ff;
      if (wr_en) begin
         filled_in[seq_idx] = 1'b1;
      end
      if (cmd.emit_ack) begin
         cnt_in = '0;
      end
      if (cmd.emit_dlv) begin
         filled_in[exp_ff] = 1'b0;
         exp_in            = exp_next;
         cnt_in            = cnt_ff + 1'b1;
      end
   end

   assign sts.head_empty = !filled_ff[exp_ff];
   assign sts.dlv_last   = (cnt_ff == CNT_W'(WINDOW - 1)) || !filled_ff[exp_next];
   assign sts.out_free   = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.emit_ack || cmd.emit_dlv) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         exp_ff       <= '0;
         filled_ff    <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         exp_ff       <= exp_in;
         filled_ff    <= filled_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_ack) begin
         rsp_kind_ff <= KIND_ACK;
         rsp_last_ff <= sts.head_empty;
         rsp_num_ff  <= seq_ff;
         rsp_chk_ff  <= ACK_CHECK_W'(seq_ff) + ACK_CHECK_W'(ACK_CHECK_BASE);
         rsp_pay_ff  <= '0;
      end else if (cmd.emit_dlv) begin
         rsp_kind_ff <= KIND_DELIVER;
         rsp_last_ff <= sts.dlv_last;
         rsp_num_ff  <= '0;
         rsp_chk_ff  <= '0;
         rsp_pay_ff  <= rd_data;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = RSP_DATA_W'({rsp_pay_ff, rsp_chk_ff, rsp_num_ff});

endmodule

/* rtl/selective_repeat_receiver.sv */
// Top level of the selective repeat receiver: joins controller and datapath.
// Depends on srr_pkg, srr_ctrl, srr_datapath and srr_ram.
//
// The req_ channel takes one packet word: sequence number, ack field,
// checksum and 20 payload bytes. A packet with a bad checksum, a number at or
// above the sequence space or a number outside the receive window is dropped
// and gives no result word. A good packet is stored in its slot unless that
// slot already holds one, and is answered on the rsp_ channel by an
// acknowledgement word, followed by one delivery word for each stored packet
// in the run that starts at the expected number. rsp_tlast marks the final
// word of each packet; rsp_tuser gives the kind of word.
// Timing: a packet is loaded in IDLE_S and checked in CHECK_S, then the single
// result register issues one result word per cycle while rsp_tready stays high;
// no new packet is taken until the last one is dropped or its final result word
// is issued. A stalled rsp_tready holds the result register and the controller
// waits; no word is lost. Reset clears the expected number and all slot fill
// bits at once; req_tready is held low while reset is high, and a word can be
// accepted from the first cycle after.
module selective_repeat_receiver #(
   parameter int SEQ_SPACE = srr_pkg::SEQ_SPACE_DEF,
   parameter int WINDOW    = srr_pkg::WINDOW_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // seq_number, ack_number, check_value, payload_low, payload_mid,
   // payload_high, zero fill
   input  logic [srr_pkg::REQ_DATA_W-1:0]  req_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // acked_number, ack_check, out_low, out_mid, out_high, zero fill
   output logic [srr_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // result_kind
   output logic                            rsp_tuser,
   output logic                            rsp_tlast
);
   import srr_pkg::*;

   cmd_type    cmd;
   status_type sts;

   srr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   srr_datapath #(
      .SEQ_SPACE (SEQ_SPACE),
      .WINDOW    (WINDOW)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   a_busy_after_accept : assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("packet accepted while the previous one is being checked");

   a_deliver_filled : assert property (@(posedge clock) disable iff (reset)
      cmd.emit_dlv |-> !sts.head_empty)
      else $error("delivery issued from an empty slot");

   a_commit_then_ack : assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> (!req_tready && !cmd.emit_dlv))
      else $error("stored packet not followed by its acknowledgement");

endmodule

/* test/testbench.sv */
`timescale 1ns / 100ps
// Testbench for selective_repeat_receiver: drives packet words, predicts every
// acknowledgement and delivery word in a scoreboard class and checks them in order.
// Depends on srr_pkg and the RTL of the block.
module testbench;
   import srr_pkg::*;

   localparam int SPACE          = SEQ_SPACE_DEF;
   localparam int WIN            = WINDOW_DEF;
   localparam int SEQ_TOP        = (1 << SEQ_W) - 1;
   localparam int CHK_LSB        = SEQ_W + ACK_W;
   localparam int PAY_LSB        = SEQ_W + ACK_W + CHK_W;
   localparam int RSP_PAY_LSB    = SEQ_W + ACK_CHECK_W;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int HOLD_CYCLES    = 300;
   localparam int GOOD_PER_PHASE = 82;
   localparam int MAX_REPORTS    = 40;

   typedef enum int {
      FREE_RUN,
      SENDER_GAPS,
      RECEIVER_STALLS,
      BOTH_IDLE
   } phase_type;

   typedef struct packed {
      logic                   kind;
      logic [SEQ_W-1:0]       acked;
      logic [ACK_CHECK_W-1:0] check;
      logic [HIGH_W-1:0]      high;
      logic [MID_W-1:0]       mid;
      logic [LOW_W-1:0]       low;
      logic                   last;
   } rsp_word_type;

   class arq_scoreboard;
      logic [SEQ_W-1:0] next_seq;
      logic             slot_full [SPACE];
      logic [PAY_W-1:0] slot_payload [SPACE];
      rsp_word_type     pending_words [$];
      int               failures;
      int               words_checked;
      int               longest_run;

      function new();
         next_seq      = '0;
         failures      = 0;
         words_checked = 0;
         longest_run   = 0;
         foreach (slot_full[i]) slot_full[i] = 1'b0;
      endfunction

      function int packet_sum(logic [SEQ_W-1:0] seq, logic signed [ACK_W-1:0] ack,
                              logic [PAY_W-1:0] payload);
         int total;
         total = int'(seq) + int'(ack);
         for (int i = 0; i < PAY_BYTES; i++) total += int'(payload[8*i +: 8]);
         return total;
      endfunction

      // Returns the number of words the packet will cause.
      function int note_packet(logic [REQ_DATA_W-1:0] word);
         logic [SEQ_W-1:0]        seq;
         logic signed [ACK_W-1:0] ack;
         logic signed [CHK_W-1:0] chk;
         logic [PAY_W-1:0]        payload;
         rsp_word_type            w;
         int                      run;
         seq     = word[0 +: SEQ_W];
         ack     = word[SEQ_W +: ACK_W];
         chk     = word[CHK_LSB +: CHK_W];
         payload = word[PAY_LSB +: PAY_W];
         if (packet_sum(seq, ack, payload) != int'(chk)) return 0;
         if (int'(seq) >= SPACE) return 0;
         if ((int'(seq) + SPACE - int'(next_seq)) % SPACE >= WIN) return 0;
         if (!slot_full[seq]) begin
            slot_full[seq]    = 1'b1;
            slot_payload[seq] = payload;
         end
         w       = '0;
         w.kind  = KIND_ACK;
         w.acked = seq;
         w.check = ACK_CHECK_W'(int'(seq) + ACK_CHECK_BASE);
         pending_words.push_back(w);
         run = 0;
         while (run < WIN && slot_full[next_seq]) begin
            w                     = '0;
            w.kind                = KIND_DELIVER;
            {w.high, w.mid, w.low} = slot_payload[next_seq];
            pending_words.push_back(w);
            slot_full[next_seq] = 1'b0;
            next_seq            = SEQ_W'((int'(next_seq) + 1) % SPACE);
            run++;
         end
         pending_words[pending_words.size() - 1].last = 1'b1;
         if (run > longest_run) longest_run = run;
         return run + 1;
      endfunction

      function void report_field(string name, logic [LOW_W-1:0] want, logic [LOW_W-1:0] seen);
         if (seen !== want) begin
            failures++;
            if (failures <= MAX_REPORTS)
               $display("%0t: %s expected %h, got %h", $time, name, want, seen);
         end
      endfunction

      function void check_word(rsp_word_type seen);
         rsp_word_type want;
         if (pending_words.size() == 0) begin
            failures++;
            if (failures <= MAX_REPORTS)
               $display("%0t: word with nothing expected, got %h", $time, seen);
            return;
         end
         want = pending_words.pop_front();
         words_checked++;
         report_field("result_kind", LOW_W'(want.kind), LOW_W'(seen.kind));
         report_field("acked_number", LOW_W'(want.acked), LOW_W'(seen.acked));
         report_field("ack_check", LOW_W'(want.check), LOW_W'(seen.check));
         report_field("out_low", want.low, seen.low);
         report_field("out_mid", want.mid, seen.mid);
         report_field("out_high", LOW_W'(want.high), LOW_W'(seen.high));
         report_field("last", LOW_W'(want.last), LOW_W'(seen.last));
      endfunction
   endclass

   logic                  clock;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;
   logic                  rsp_tlast;

   phase_type     phase       = FREE_RUN;
   int            hold_ticket = 0;
   int            holds_taken = 0;
   int            hold_left   = 0;
   int            idle_cycles = 0;
   int            packets_sent     = 0;
   int            packets_answered = 0;
   arq_scoreboard board;

   selective_repeat_receiver dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   // Result side: checks each accepted word, then decides the next ready value.
   always @(posedge clock) begin
      rsp_word_type seen;
      seen.kind                    = rsp_tuser;
      seen.acked                   = rsp_tdata[0 +: SEQ_W];
      seen.check                   = rsp_tdata[SEQ_W +: ACK_CHECK_W];
      {seen.high, seen.mid, seen.low} = rsp_tdata[RSP_PAY_LSB +: PAY_W];
      seen.last                    = rsp_tlast;
      if (!reset && rsp_tvalid && rsp_tready) board.check_word(seen);
      if (hold_left > 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (holds_taken != hold_ticket) begin
         holds_taken <= hold_ticket;
         hold_left   <= HOLD_CYCLES;
         rsp_tready  <= 1'b0;
      end else begin
         rsp_tready <= !((phase == RECEIVER_STALLS && $urandom_range(0, 99) < 62) ||
                         (phase == BOTH_IDLE && $urandom_range(0, 99) < 11));
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("[selective_repeat_receiver] ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic logic [PAY_W-1:0] random_payload();
      int mode;
      mode = $urandom_range(0, 9);
      if (mode == 0) return '1;
      if (mode == 1) return '0;
      return {$urandom, $urandom, $urandom, $urandom, $urandom};
   endfunction

   function automatic int random_ack();
      if ($urandom_range(0, 9) == 0) return int'($urandom_range(0, 31)) - 16;
      return int'($urandom_range(0, 16)) - 1;
   endfunction

   function automatic logic [REQ_DATA_W-1:0] good_packet(int seq, int ack,
                                                        logic [PAY_W-1:0] payload);
      logic [REQ_DATA_W-1:0] word;
      word                     = '0;
      word[0 +: SEQ_W]         = SEQ_W'(seq);
      word[SEQ_W +: ACK_W]     = ACK_W'(ack);
      word[CHK_LSB +: CHK_W]   = CHK_W'(board.packet_sum(SEQ_W'(seq), ACK_W'(ack), payload));
      word[PAY_LSB +: PAY_W]   = payload;
      return word;
   endfunction

   task automatic send_packet(input logic [REQ_DATA_W-1:0] word, output int results);
      while ((phase == SENDER_GAPS && $urandom_range(0, 99) < 62) ||
             (phase == BOTH_IDLE && $urandom_range(0, 99) < 11)) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= word;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      results = board.note_packet(word);
      packets_sent++;
      if (results > 0) packets_answered++;
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (board.pending_words.size() != 0) @(posedge clock);
   endtask

   task automatic run_directed();
      logic [REQ_DATA_W-1:0] word;
      int                    n;
      send_packet(good_packet(0, -1, '0), n);
      send_packet(good_packet(1, 15, '1), n);
      send_packet(good_packet(SEQ_TOP, 3, random_payload()), n);
      send_packet(good_packet(SPACE, 0, random_payload()), n);
      word = good_packet(2, 4, random_payload());
      word[CHK_LSB] = ~word[CHK_LSB];
      send_packet(word, n);
      send_packet(good_packet(2 + WIN, 0, random_payload()), n);
      // Fill the window from its far edge so that the head releases a full run.
      for (int s = 1 + WIN; s >= 3; s--)
         send_packet(good_packet(s, random_ack(), random_payload()), n);
      send_packet(good_packet(5, 2, '1), n);
      send_packet(good_packet(2, 0, random_payload()), n);
      send_packet(good_packet(7, 1, random_payload()), n);
      send_packet(good_packet(8, -16, random_payload()), n);
      send_packet(good_packet(9, -16, '0), n);
      send_packet(good_packet(11, random_ack(), random_payload()), n);
      send_packet(good_packet(10, random_ack(), random_payload()), n);
      word = good_packet($urandom_range(0, SEQ_TOP), random_ack(), random_payload());
      word[CHK_LSB +: CHK_W] = $urandom;
      send_packet(word, n);
   endtask

   task automatic run_random(input int good_target, input bit with_hold);
      logic [REQ_DATA_W-1:0] word;
      int                    good;
      int                    sent;
      int                    choice;
      int                    seq;
      int                    n;
      good = 0;
      sent = 0;
      while (good < good_target) begin
         if (with_hold && sent == 30) hold_ticket <= hold_ticket + 1;
         choice = $urandom_range(0, 99);
         seq    = (int'(board.next_seq) + $urandom_range(0, WIN - 1)) % SPACE;
         if (choice < 8)
            seq = (int'(board.next_seq) + WIN + $urandom_range(0, SPACE - WIN - 1)) % SPACE;
         else if (choice < 14)
            seq = $urandom_range(SPACE, SEQ_TOP);
         word = good_packet(seq, random_ack(), random_payload());
         if (choice >= 86) word[CHK_LSB +: CHK_W] = $urandom;
         send_packet(word, n);
         sent++;
         if (n > 0) good++;
      end
   endtask

   initial begin
      board = new();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      run_directed();
      drain();
      for (int p = FREE_RUN; p <= BOTH_IDLE; p++) begin
         phase <= phase_type'(p);
         run_random(GOOD_PER_PHASE, p == FREE_RUN);
         drain();
      end
      repeat (20) @(posedge clock);
      $display("Sent %0d packets, %0d answered, %0d result words checked, longest run %0d.",
               packets_sent, packets_answered, board.words_checked, board.longest_run);
      $display("Covered free flow, sender gaps, receiver stalls, both, and a long output hold.");
      if (board.failures == 0 && board.pending_words.size() == 0) begin
         $display("[selective_repeat_receiver] OK");
      end else begin
         $display("[selective_repeat_receiver] ERROR");
      end
      $finish;
   end

endmodule
